### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks used by the top design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TSRE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tsre property violated");

// condition must never be seen outside reset
`define TSRE_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tsre forbidden condition seen");

`endif

### design/tsre_pkg.sv
// ---------------------------------------------------------------------------
// tsre_pkg
// types, codes and helpers of the thermocouple spike reject filter
// ---------------------------------------------------------------------------
package tsre_pkg;

   localparam int unsigned AddrWidth = 4;
   localparam int unsigned DataWidth = 32;

   // register indexes (byte address 4*index)
   localparam logic [1:0] REG_GAIN   = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;
   localparam logic [1:0] REG_ALPHA  = 2'd2;
   localparam logic [1:0] REG_THRESH = 2'd3;

   localparam logic signed [15:0] GAIN_RESET   = 16'sd4096;
   localparam logic signed [16:0] OFFSET_RESET = 17'sd0;
   localparam logic [16:0]        ALPHA_RESET  = 17'd6554;
   localparam logic [16:0]        ALPHA_ONE    = 17'd65536;
   localparam logic [15:0]        THRESH_RESET = 16'd3840;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ST_KEPT    = 2'd0,
      ST_FAULT   = 2'd1,
      ST_SPIKE   = 2'd2,
      ST_RESTART = 2'd3
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [11:0] raw_count;
      logic        sensor_fault;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        elapsed_ms;
      logic signed [23:0] calibrated_q8;
      logic signed [23:0] filtered_q8;
      logic [23:0]        jump_q8;
      logic [31:0]        spikes_seen;
      logic [31:0]        samples_kept;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] gain_q12;
      logic signed [16:0] offset_q8;
      logic [16:0]        alpha_q16;
      logic [15:0]        spike_threshold_q8;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic weigh;
      logic finish;
   } cmd_type;

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -28'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = 24'(v);
      end
      return r;
   endfunction

endpackage

### design/tsre_csr.sv
// ---------------------------------------------------------------------------
// tsre_csr
// apb register file holding calibration, alpha and spike threshold
// ---------------------------------------------------------------------------
module tsre_csr
   import tsre_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg,
   output logic                 alpha_load
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [16:0] alpha_wr;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite;
   assign reg_idx  = paddr[3:2];
   assign alpha_wr = pwdata[16:0];

   always_comb begin
      cfg_in     = cfg_ff;
      alpha_load = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_GAIN:   cfg_in.gain_q12 = $signed(pwdata[15:0]);
            REG_OFFSET: cfg_in.offset_q8 = $signed(pwdata[16:0]);
            REG_ALPHA: begin
               // out of range alpha is dropped and does not unprime the filter
               if (alpha_wr != '0 && alpha_wr <= ALPHA_ONE) begin
                  cfg_in.alpha_q16 = alpha_wr;
                  alpha_load       = 1'b1;
               end
            end
            REG_THRESH: cfg_in.spike_threshold_q8 = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_q12           <= GAIN_RESET;
         cfg_ff.offset_q8          <= OFFSET_RESET;
         cfg_ff.alpha_q16          <= ALPHA_RESET;
         cfg_ff.spike_threshold_q8 <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN:   prdata = {16'b0, cfg_ff.gain_q12};
         REG_OFFSET: prdata = {15'b0, cfg_ff.offset_q8};
         REG_ALPHA:  prdata = {15'b0, cfg_ff.alpha_q16};
         REG_THRESH: prdata = {16'b0, cfg_ff.spike_threshold_q8};
         default:    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/tsre_ctrl.sv
// ---------------------------------------------------------------------------
// tsre_ctrl
// sequencer stepping one request through calibrate, weigh and finish
// ---------------------------------------------------------------------------
module tsre_ctrl
   import tsre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CAL  = 4'b0010,
      S_UPD  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // result register can take a new response when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.calc    = (state_ff == S_CAL);
   assign cmd.weigh   = (state_ff == S_UPD);
   assign cmd.finish  = (state_ff == S_FIN) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_CAL;
            end
         end
         S_CAL:  state_in = S_UPD;
         S_UPD:  state_in = S_FIN;
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/tsre_dp.sv
// ---------------------------------------------------------------------------
// tsre_dp
// calibration multiply, spike test, average update and filter state
// ---------------------------------------------------------------------------
module tsre_dp
   import tsre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    alpha_load,
   output rsp_type rsp_data
);

   // captured request
   logic        op_ff;
   logic        fault_ff;
   logic [31:0] now_ff;

   // pipeline registers
   logic signed [34:0] prod_ff, prod_in;
   logic signed [23:0] cal_ff, cal_in;
   logic signed [41:0] wprod_ff, wprod_in;
   logic [23:0]        jump_ff, jump_in;
   logic               spike_ff, spike_in;

   // filter state
   logic signed [23:0] avg_ff, avg_in;
   logic               primed_ff, primed_in;
   logic [31:0]        origin_ff, origin_in;
   logic [31:0]        spikes_ff, spikes_in;
   logic [31:0]        kept_ff, kept_in;

   rsp_type rsp_ff, rsp_in;

   logic signed [35:0] rnd_full;
   logic signed [27:0] cal_sum;
   logic signed [24:0] diff;
   logic signed [24:0] diff_abs;
   logic signed [42:0] wsum;
   logic signed [42:0] wshift;
   logic signed [27:0] upd_sum;
   logic signed [23:0] avg_upd;
   logic [31:0]        elapsed;

   // count * 64 times q12 gain
   assign prod_in = 35'($signed({1'b0, req_data.raw_count, 6'b0})) * 35'(cfg.gain_q12);

   // round to q8, add offset, saturate
   assign rnd_full = (36'(prod_ff) + 36'sd2048) >>> 12;
   assign cal_sum  = 28'($signed(rnd_full[24:0])) + 28'(cfg.offset_q8);
   assign cal_in   = sat24(cal_sum);

   assign diff     = 25'(cal_ff) - 25'(avg_ff);
   assign diff_abs = (diff < 0) ? -diff : diff;
   assign jump_in  = primed_ff ? diff_abs[23:0] : '0;
   assign spike_in = primed_ff && (cfg.spike_threshold_q8 != '0)
                     && (jump_in > {8'b0, cfg.spike_threshold_q8});
   assign wprod_in = 42'($signed({1'b0, cfg.alpha_q16})) * 42'(diff);

   assign wsum    = 43'(wprod_ff) + 43'sd32768;
   assign wshift  = wsum >>> 16;
   assign upd_sum = 28'(avg_ff) + 28'($signed(wshift[26:0]));
   assign avg_upd = sat24(upd_sum);

   assign elapsed = now_ff - origin_ff;

   always_comb begin
      avg_in    = avg_ff;
      primed_in = primed_ff;
      origin_in = origin_ff;
      spikes_in = spikes_ff;
      kept_in   = kept_ff;

      rsp_in.status        = ST_KEPT;
      rsp_in.elapsed_ms    = elapsed;
      rsp_in.calibrated_q8 = cal_ff;
      rsp_in.filtered_q8   = '0;
      rsp_in.jump_q8       = jump_ff;
      rsp_in.spikes_seen   = spikes_ff;
      rsp_in.samples_kept  = kept_ff;

      if (op_ff == OP_RESTART) begin
         origin_in            = now_ff;
         avg_in               = '0;
         primed_in            = 1'b0;
         spikes_in            = '0;
         kept_in              = '0;
         rsp_in.status        = ST_RESTART;
         rsp_in.elapsed_ms    = '0;
         rsp_in.calibrated_q8 = '0;
         rsp_in.jump_q8       = '0;
         rsp_in.spikes_seen   = '0;
         rsp_in.samples_kept  = '0;
      end else if (fault_ff) begin
         rsp_in.status        = ST_FAULT;
         rsp_in.calibrated_q8 = '0;
         rsp_in.jump_q8       = '0;
         rsp_in.filtered_q8   = primed_ff ? avg_ff : '0;
      end else if (spike_ff) begin
         spikes_in            = spikes_ff + 32'd1;
         rsp_in.status        = ST_SPIKE;
         rsp_in.filtered_q8   = avg_ff;
         rsp_in.spikes_seen   = spikes_in;
      end else begin
         // first kept sample seeds the average
         avg_in              = primed_ff ? avg_upd : cal_ff;
         primed_in           = 1'b1;
         kept_in             = kept_ff + 32'd1;
         rsp_in.filtered_q8  = avg_in;
         rsp_in.samples_kept = kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_data.operation;
         fault_ff <= req_data.sensor_fault;
         now_ff   <= req_data.now_ms;
         prod_ff  <= prod_in;
      end
      if (cmd.calc) begin
         cal_ff <= cal_in;
      end
      if (cmd.weigh) begin
         wprod_ff <= wprod_in;
         jump_ff  <= jump_in;
         spike_ff <= spike_in;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff    <= '0;
         primed_ff <= 1'b0;
         origin_ff <= '0;
         spikes_ff <= '0;
         kept_ff   <= '0;
      end else if (cmd.finish) begin
         avg_ff    <= avg_in;
         primed_ff <= primed_in;
         origin_ff <= origin_in;
         spikes_ff <= spikes_in;
         kept_ff   <= kept_in;
      end else if (alpha_load) begin
         primed_ff <= 1'b0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### design/thermocouple_spike_reject_ema.sv
// ---------------------------------------------------------------------------
// thermocouple_spike_reject_ema
// calibrated, spike filtered moving average of thermocouple samples
// ---------------------------------------------------------------------------
// usage:
//   req_valid/req_ready carry a request: a sample (count, fault flag, time)
//   or a restart that sets the time base and clears filter and counters.
//   rsp_valid/rsp_ready return exactly one response per request.
//   psel/penable/pwrite/paddr/pwdata program gain, offset, alpha and spike
//   threshold at byte addresses 0, 4, 8, 12; write only while idle.
// timing:
//   a request is taken in the idle cycle, then calibrate, weigh and finish
//   follow in turn; the response is registered in finish, which waits for
//   a free output register; req_ready returns the cycle after, so requests
//   never overlap. gain and alpha multiplies are done in separate steps.
// reset:
//   synchronous; registers return to their defaults, average unprimed,
//   time base and counters zero, no response pending.
// stall:
//   a held response stays in the output register; the next request is
//   still taken and waits in the finish step until the register frees up.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module thermocouple_spike_reject_ema
   import tsre_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready
);

   cfg_type cfg;
   cmd_type cmd;
   logic    alpha_load;
   logic    rsp_is_restart;
   logic    rsp_is_fault;
   logic    rsp_is_kept;
   logic    restart_clean;
   logic    kept_in_band;

   tsre_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .alpha_load (alpha_load)
   );

   tsre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tsre_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .cfg        (cfg),
      .alpha_load (alpha_load),
      .rsp_data   (rsp_data)
   );

   assign rsp_is_restart = rsp_valid && (rsp_data.status == ST_RESTART);
   assign rsp_is_fault   = rsp_valid && (rsp_data.status == ST_FAULT);
   assign rsp_is_kept    = rsp_valid && (rsp_data.status == ST_KEPT);
   assign restart_clean  = (rsp_data.elapsed_ms == '0) && (rsp_data.spikes_seen == '0)
                           && (rsp_data.samples_kept == '0);
   assign kept_in_band   = (cfg.spike_threshold_q8 == '0)
                           || (rsp_data.jump_q8 <= 24'(cfg.spike_threshold_q8));

   // one request in flight at a time
   `TSRE_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready)

   // restart response reports a fresh time base and cleared counters
   `TSRE_ASSERT(a_restart_clean, clock, reset, rsp_is_restart |-> restart_clean)

   // faulted sample never carries a calibrated value
   `TSRE_NEVER(a_fault_no_cal, clock, reset, rsp_is_fault && rsp_data.calibrated_q8 != '0)

   // a kept sample stays within the spike threshold
   `TSRE_ASSERT(a_kept_in_band, clock, reset, rsp_is_kept |-> kept_in_band)

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the thermocouple spike reject filter: an in-bench
// predictor of calibration, spike rejection, averaging and counters checks
// every response field; the registers are reprogrammed between phases
// ---------------------------------------------------------------------------
module tb_top
   import tsre_pkg::*;
();

   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   thermocouple_spike_reject_ema u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   // predicted filter state and register copy
   cfg_type      filter_cfg;
   longint       avg_q8;
   logic         avg_primed;
   logic [31:0]  time_base;
   logic [31:0]  spike_cnt;
   logic [31:0]  kept_cnt;

   req_type      pending_requests[$];
   rsp_type      expected_readings[$];
   rsp_type      want_rsp;
   int           issued_count = 0;
   int           retired_count = 0;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           send_gap = 0;
   int           hold_left = 0;
   bit           idle_enabled = 1'b1;
   int           walk_level = 2000;
   logic [31:0]  walk_ms = '0;

   function automatic longint clip24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // advance the predicted filter by one request and queue its response
   task automatic filter_step(input req_type r);
      rsp_type o;
      longint  cal;
      longint  jump;
      longint  diff;
      o = '0;
      cal = 0;
      jump = 0;
      if (r.operation == OP_RESTART) begin
         time_base = r.now_ms;
         avg_q8 = 0;
         avg_primed = 1'b0;
         spike_cnt = '0;
         kept_cnt = '0;
         o.status = ST_RESTART;
      end else if (r.sensor_fault) begin
         o.status = ST_FAULT;
      end else begin
         cal = (longint'(r.raw_count) * 64 * longint'($signed(filter_cfg.gain_q12)) + 2048)
               >>> 12;
         cal = clip24(cal + longint'($signed(filter_cfg.offset_q8)));
         if (avg_primed) begin
            jump = (cal >= avg_q8) ? cal - avg_q8 : avg_q8 - cal;
         end
         if (avg_primed && filter_cfg.spike_threshold_q8 != 0 &&
             jump > longint'(filter_cfg.spike_threshold_q8)) begin
            spike_cnt = spike_cnt + 1;
            o.status = ST_SPIKE;
         end else begin
            if (!avg_primed) begin
               avg_q8 = cal;
               avg_primed = 1'b1;
            end else begin
               diff = cal - avg_q8;
               avg_q8 = clip24(avg_q8 +
                  ((longint'(filter_cfg.alpha_q16) * diff + 32768) >>> 16));
            end
            kept_cnt = kept_cnt + 1;
            o.status = ST_KEPT;
         end
      end
      o.elapsed_ms    = r.now_ms - time_base;
      o.calibrated_q8 = 24'(cal);
      o.filtered_q8   = avg_primed ? 24'(avg_q8) : 24'sd0;
      o.jump_q8       = 24'(jump);
      o.spikes_seen   = spike_cnt;
      o.samples_kept  = kept_cnt;
      expected_readings.push_back(o);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         if (mismatch_count < 10) begin
            $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
         mismatch_count++;
      end
   endtask

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_enabled || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            filter_step(req_data);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
               issued_count++;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("response with nothing expected: %h", rsp_data);
               end
               mismatch_count++;
            end else begin
               want_rsp = expected_readings.pop_front();
               retired_count++;
               compare_field("status", 32'(want_rsp.status), 32'(rsp_data.status));
               compare_field("elapsed_ms", want_rsp.elapsed_ms, rsp_data.elapsed_ms);
               compare_field("calibrated_q8", 32'(want_rsp.calibrated_q8),
                             32'(rsp_data.calibrated_q8));
               compare_field("filtered_q8", 32'(want_rsp.filtered_q8),
                             32'(rsp_data.filtered_q8));
               compare_field("jump_q8", 32'(want_rsp.jump_q8), 32'(rsp_data.jump_q8));
               compare_field("spikes_seen", want_rsp.spikes_seen, rsp_data.spikes_seen);
               compare_field("samples_kept", want_rsp.samples_kept, rsp_data.samples_kept);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            hold_left = pick_gap();
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= AddrWidth'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // register is written at this edge
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_GAIN:   filter_cfg.gain_q12 = value[15:0];
         REG_OFFSET: filter_cfg.offset_q8 = value[16:0];
         REG_ALPHA: begin
            // out of range alpha is dropped and does not unprime the average
            if (value[16:0] >= 17'd1 && value[16:0] <= ALPHA_ONE) begin
               filter_cfg.alpha_q16 = value[16:0];
               avg_primed = 1'b0;
            end
         end
         default:    filter_cfg.spike_threshold_q8 = value[15:0];
      endcase
   endtask

   task automatic wait_for_idle();
      while (pending_requests.size() != 0 || issued_count != retired_count) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_item(input logic op, input logic [11:0] raw, input logic fault,
                             input logic [31:0] now);
      req_type r;
      r.operation = op;
      r.raw_count = raw;
      r.sensor_fault = fault;
      r.now_ms = now;
      pending_requests.push_back(r);
   endtask

   // mostly a slowly wandering reading, with jumps, faults and restarts mixed in
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int          step;
      int          level;
      pick = $urandom_range(0, 99);
      r.operation = OP_SAMPLE;
      r.sensor_fault = 1'b0;
      r.raw_count = 12'($urandom_range(0, 4095));
      walk_ms = walk_ms + $urandom_range(1, 400);
      if (pick % 33 == 0) walk_ms = $urandom();
      r.now_ms = walk_ms;
      if (pick < 5) begin
         r.operation = OP_RESTART;
         r.sensor_fault = 1'($urandom_range(0, 1));
      end else if (pick < 11) begin
         r.sensor_fault = 1'b1;
      end else if (pick < 14) begin
         r.raw_count = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
      end else if (pick >= 26) begin
         if ($urandom_range(0, 24) == 0) walk_level = $urandom_range(0, 4095);
         step = int'($urandom_range(0, 180)) - 90;
         level = walk_level + step;
         if (level < 0) level = 0;
         if (level > 4095) level = 4095;
         walk_level = (walk_level + level) / 2;
         r.raw_count = 12'(level);
      end
      return r;
   endfunction

   task automatic program_phase(input int phase);
      logic [31:0] gain;
      logic [31:0] offset;
      logic [31:0] alpha;
      logic [31:0] thresh;
      case (phase)
         1: begin
            gain = 32'h7FFF; offset = 32'h0FFFF; alpha = 32'(ALPHA_ONE); thresh = 32'd0;
         end
         2: begin
            gain = 32'h8000; offset = 32'h10000; alpha = 32'd1; thresh = 32'hFFFF;
         end
         3: begin
            gain = 32'(GAIN_RESET); offset = 32'd0; alpha = 32'(ALPHA_RESET);
            thresh = 32'(THRESH_RESET);
         end
         5: begin
            gain = 32'd5000; offset = 32'h1FC18; alpha = 32'd32768; thresh = 32'd500;
         end
         default: begin
            gain = $urandom_range(0, 65535);
            offset = $urandom_range(0, 131071);
            alpha = $urandom_range(1, 65536);
            thresh = $urandom_range(0, 8000);
         end
      endcase
      csr_write(REG_GAIN, gain);
      csr_write(REG_OFFSET, offset);
      csr_write(REG_ALPHA, alpha);
      csr_write(REG_THRESH, thresh);
      if (phase == 3) begin
         csr_write(REG_ALPHA, 32'd0);
         csr_write(REG_ALPHA, 32'h1FFFF);
         csr_write(REG_ALPHA, 32'd65537);
      end
   endtask

   initial begin
      filter_cfg.gain_q12 = GAIN_RESET;
      filter_cfg.offset_q8 = OFFSET_RESET;
      filter_cfg.alpha_q16 = ALPHA_RESET;
      filter_cfg.spike_threshold_q8 = THRESH_RESET;
      avg_q8 = 0;
      avg_primed = 1'b0;
      time_base = '0;
      spike_cnt = '0;
      kept_cnt = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset settings
      queue_item(OP_SAMPLE, 12'd0, 1'b0, 32'd0);
      queue_item(OP_SAMPLE, 12'hFFF, 1'b0, 32'd1);
      queue_item(OP_SAMPLE, 12'hFFF, 1'b1, 32'd2);
      queue_item(OP_SAMPLE, 12'd60, 1'b0, 32'd3);
      queue_item(OP_SAMPLE, 12'd10, 1'b0, 32'd5);
      queue_item(OP_RESTART, 12'hFFF, 1'b1, 32'hFFFF_FFF0);
      queue_item(OP_SAMPLE, 12'd0, 1'b1, 32'hFFFF_FFF8);
      queue_item(OP_SAMPLE, 12'hFFF, 1'b0, 32'h0000_0010);
      queue_item(OP_SAMPLE, 12'd0, 1'b0, 32'h0000_0020);
      queue_item(OP_SAMPLE, 12'hFFE, 1'b0, 32'h5555_5555);
      queue_item(OP_SAMPLE, 12'h555, 1'b0, 32'hAAAA_AAAA);
      queue_item(OP_SAMPLE, 12'hAAA, 1'b0, 32'hFFFF_FFFF);
      queue_item(OP_RESTART, 12'd0, 1'b0, 32'd0);
      // jump exactly at the threshold is kept, one step further is a spike
      queue_item(OP_SAMPLE, 12'd100, 1'b0, 32'd7);
      queue_item(OP_SAMPLE, 12'd160, 1'b0, 32'd8);
      queue_item(OP_SAMPLE, 12'd167, 1'b0, 32'd9);
      queue_item(OP_SAMPLE, 12'd166, 1'b0, 32'd10);
      queue_item(OP_RESTART, 12'hAAA, 1'b0, 32'h8000_0000);
      queue_item(OP_SAMPLE, 12'd1, 1'b0, 32'h8000_0001);
      wait_for_idle();

      for (int phase = 1; phase <= 6; phase++) begin
         program_phase(phase);
         idle_enabled = (phase != 4);
         // sender holds back mid-phase until every response is in
         for (int half = 0; half < 2; half++) begin
            for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
               pending_requests.push_back(random_request());
            end
            wait_for_idle();
         end
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/tsre_pkg.sv
design/tsre_csr.sv
design/tsre_ctrl.sv
design/tsre_dp.sv
design/thermocouple_spike_reject_ema.sv
tb/tb_top.sv
